// ===== hdl/fctl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fctl_pkg
// types, codes and helpers shared by the flux limiter controller and datapath
// ----------------------------------------------------------------------------
package fctl_pkg;

   localparam int unsigned CELLS     = 1024;
   localparam int unsigned CELL_W    = $clog2(CELLS);
   localparam int unsigned DIV_STEPS = 16;
   localparam logic [16:0] ONE_Q16   = 17'd65536;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_ACC     = 2'd1,
      OP_COMPUTE = 2'd2,
      OP_CORRECT = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MUL_VU    = 2'd0,
      MUL_VBL   = 2'd1,
      MUL_VBH   = 2'd2,
      MUL_ALPHA = 2'd3
   } mul_sel_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic [9:0]         cell_a;
      logic [9:0]         cell_b;
      logic               two_cells;
      logic signed [31:0] flux_low_order;
      logic signed [31:0] flux_high_order;
      logic [31:0]        volume_old;
      logic [31:0]        volume_new;
      logic signed [31:0] cell_value;
      logic signed [31:0] bound_low;
      logic signed [31:0] bound_high;
   } req_type;

   typedef struct packed {
      logic signed [31:0] corrected_flux;
      logic [16:0]        limiter_alpha;
   } rsp_type;

   typedef struct packed {
      logic              load_item;
      logic              sel_b;
      logic              sel_cnt;
      logic [CELL_W-1:0] cnt;
      logic              wr_params;
      logic              wr_sums;
      logic              sum_clear;
      logic              wr_lim;
      logic              lim_clear;
      mul_sel_type       mul_sel;
      logic              base_en;
      logic              nlo_en;
      logic              nhi_en;
      logic              div_setup;
      logic              div_neg;
      logic              div_step;
      logic              rn_en;
      logic              lima_en;
      logic              alpha_en;
      logic              rsp_load;
   } cmd_type;

   typedef struct packed {
      op_type operation;
      logic   two_cells;
      logic   rsp_full;
   } status_type;

   // saturate to the signed 48-bit range
   function automatic logic [47:0] sat48(input logic signed [49:0] x);
      logic [47:0] r;
      if (x > 50'sh0_7FFF_FFFF_FFFF) r = 48'h7FFF_FFFF_FFFF;
      else if (x < -50'sh0_8000_0000_0000) r = 48'h8000_0000_0000;
      else r = x[47:0];
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/fctl_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fctl_datapath
// cell memories, shared multiplier, serial divider and result register
// ----------------------------------------------------------------------------
module fctl_datapath import fctl_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire req_type    req_data,
   input  wire cmd_type    cmd,
   output status_type      status,
   input  wire logic       rsp_ready,
   output logic            rsp_valid,
   output rsp_type         rsp_data
);

   logic [95:0]  params_mem [CELLS];
   logic [63:0]  bounds_mem [CELLS];
   logic [143:0] sum_mem    [CELLS];
   logic [33:0]  lim_mem    [CELLS];

   req_type             item_ff;
   logic [95:0]         rd_params_ff;
   logic [63:0]         rd_bounds_ff;
   logic [143:0]        rd_sum_ff;
   logic [33:0]         rd_lim_ff;
   logic [CELL_W:0]     count_ff;
   logic signed [65:0]  prod_ff;
   logic signed [49:0]  base_ff;
   logic signed [50:0]  nlo_ff, nhi_ff;
   logic [47:0]         rem_ff, den_ff;
   logic [16:0]         q_ff, rn_ff;
   logic                one_ff;
   logic [33:0]         lim_a_ff;
   logic [16:0]         alpha_ff;
   rsp_type             rsp_ff;
   logic                rsp_valid_ff;

   logic [CELL_W-1:0]   addr;
   logic signed [33:0]  lo_x, ho_x, d, dd, lon, pos_add, neg_add;
   logic signed [47:0]  pos_s, neg_s, dlo_s;
   logic [143:0]        sum_in;
   logic [33:0]         lim_in;
   logic signed [33:0]  mul_a, mul_b;
   logic signed [49:0]  prod_sh;
   logic signed [48:0]  neg_den;
   logic [50:0]         div_num;
   logic [47:0]         div_den;
   logic                div_sum_zero, cell_live;
   logic [48:0]         rem2;
   logic [16:0]         x_lim, y_lim, alpha;
   logic signed [34:0]  flux_sum;
   logic [CELL_W:0]     a_next;

   assign addr = cmd.sel_cnt ? cmd.cnt : (cmd.sel_b ? item_ff.cell_b : item_ff.cell_a);

   // accumulate: first cell takes d and -lo, second -d and lo
   assign lo_x    = 34'(item_ff.flux_low_order);
   assign ho_x    = 34'(item_ff.flux_high_order);
   assign d       = lo_x - ho_x;
   assign dd      = cmd.sel_b ? -d : d;
   assign lon     = cmd.sel_b ? lo_x : -lo_x;
   assign pos_add = (dd > 0) ? dd : '0;
   assign neg_add = (dd < 0) ? dd : '0;
   assign pos_s   = rd_sum_ff[47:0];
   assign neg_s   = rd_sum_ff[95:48];
   assign dlo_s   = rd_sum_ff[143:96];

   assign sum_in = cmd.sum_clear ? '0 :
                   {sat48(50'(dlo_s) + 50'(lon)),
                    sat48(50'(neg_s) + 50'(neg_add)),
                    sat48(50'(pos_s) + 50'(pos_add))};
   assign lim_in = cmd.lim_clear ? {ONE_Q16, ONE_Q16} : {rn_ff, q_ff};

   always_ff @(posedge clock) begin
      if (cmd.wr_params) begin
         params_mem[addr] <= {item_ff.cell_value, item_ff.volume_new, item_ff.volume_old};
         bounds_mem[addr] <= {item_ff.bound_high, item_ff.bound_low};
      end
      if (cmd.wr_sums) sum_mem[addr] <= sum_in;
      if (cmd.wr_lim) lim_mem[addr] <= lim_in;
      rd_params_ff <= params_mem[addr];
      rd_bounds_ff <= bounds_mem[addr];
      rd_sum_ff    <= sum_mem[addr];
      rd_lim_ff    <= lim_mem[addr];
   end

   // shared multiplier operands
   always_comb begin
      case (cmd.mul_sel)
         MUL_VU: begin
            mul_a = {2'b00, rd_params_ff[31:0]};
            mul_b = 34'(signed'(rd_params_ff[95:64]));
         end
         MUL_VBL: begin
            mul_a = {2'b00, rd_params_ff[63:32]};
            mul_b = 34'(signed'(rd_bounds_ff[31:0]));
         end
         MUL_VBH: begin
            mul_a = {2'b00, rd_params_ff[63:32]};
            mul_b = 34'(signed'(rd_bounds_ff[63:32]));
         end
         default: begin
            mul_a = ho_x - lo_x;
            mul_b = {17'd0, alpha_ff};
         end
      endcase
   end

   assign prod_sh = 50'(prod_ff >>> 16);

   // divider operands
   assign neg_den      = -49'(neg_s);
   assign div_num      = cmd.div_neg ? ((nlo_ff < 0) ? 51'(-nlo_ff) : '0)
                                     : ((nhi_ff > 0) ? 51'(nhi_ff) : '0);
   assign div_den      = cmd.div_neg ? neg_den[47:0] : pos_s;
   assign div_sum_zero = cmd.div_neg ? (neg_s == '0) : (pos_s == '0);
   assign cell_live    = {1'b0, cmd.cnt} < count_ff;
   assign rem2         = {rem_ff, 1'b0};

   // face limiter
   assign x_lim = (d > 0) ? lim_a_ff[16:0] : lim_a_ff[33:17];
   assign y_lim = (d > 0) ? rd_lim_ff[33:17] : rd_lim_ff[16:0];
   always_comb begin
      alpha = ONE_Q16;
      if (item_ff.two_cells) begin
         if (x_lim < alpha) alpha = x_lim;
         if (y_lim < alpha) alpha = y_lim;
      end
   end

   assign flux_sum = 35'(item_ff.flux_low_order) + 35'(prod_sh);
   assign a_next   = (CELL_W+1)'(item_ff.cell_a) + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.load_item) item_ff <= req_data;
      prod_ff <= 66'(mul_a) * 66'(mul_b);
      if (cmd.base_en) base_ff <= prod_sh + 50'(dlo_s);
      if (cmd.nlo_en) nlo_ff <= 51'(prod_sh) - 51'(base_ff);
      if (cmd.nhi_en) nhi_ff <= 51'(prod_sh) - 51'(base_ff);
      if (cmd.div_setup) begin
         den_ff <= div_den;
         if (!cell_live || div_sum_zero || div_num >= 51'(div_den)) begin
            one_ff <= 1'b1;
            q_ff   <= ONE_Q16;
         end else begin
            one_ff <= 1'b0;
            q_ff   <= '0;
            rem_ff <= div_num[47:0];
         end
      end else if (cmd.div_step && !one_ff) begin
         if (rem2 >= {1'b0, den_ff}) begin
            rem_ff <= 48'(rem2 - {1'b0, den_ff});
            q_ff   <= {q_ff[15:0], 1'b1};
         end else begin
            rem_ff <= rem2[47:0];
            q_ff   <= {q_ff[15:0], 1'b0};
         end
      end
      if (cmd.rn_en) rn_ff <= q_ff;
      if (cmd.lima_en) lim_a_ff <= rd_lim_ff;
      if (cmd.alpha_en) alpha_ff <= alpha;
      if (cmd.rsp_load) begin
         rsp_ff.limiter_alpha <= alpha_ff;
         if (flux_sum > 35'sh0_7FFF_FFFF) rsp_ff.corrected_flux <= 32'sh7FFF_FFFF;
         else if (flux_sum < -35'sh0_8000_0000) rsp_ff.corrected_flux <= 32'sh8000_0000;
         else rsp_ff.corrected_flux <= flux_sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.wr_params && a_next > count_ff) count_ff <= a_next;
         if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign status.operation = op_type'(item_ff.operation);
   assign status.two_cells = item_ff.two_cells;
   assign status.rsp_full  = rsp_valid_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_ff;

endmodule
`default_nettype wire

// ===== hdl/fctl_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fctl_ctrl
// sequencer for load, accumulate, compute walk, correct and reset clearing
// ----------------------------------------------------------------------------
module fctl_ctrl import fctl_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   input  wire logic       rsp_ready,
   output cmd_type         cmd
);

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_LOAD, ST_ACC_RD, ST_ACC_WR,
      ST_CMP_RD, ST_CMP_M0, ST_CMP_M1, ST_CMP_M2, ST_CMP_M3,
      ST_CMP_NS, ST_CMP_ND, ST_CMP_PS, ST_CMP_PD, ST_CMP_WR,
      ST_COR_RA, ST_COR_RB, ST_COR_M, ST_COR_P, ST_COR_OUT
   } state_type;

   localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);
   localparam logic [3:0]        LAST_STEP = 4'(DIV_STEPS - 1);

   state_type         state_ff;
   logic [CELL_W-1:0] cnt_ff;
   logic [3:0]        step_ff;
   logic              side_ff;
   logic              accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         step_ff  <= '0;
         side_ff  <= 1'b0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == LAST_CELL) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (accept) begin
                  side_ff  <= 1'b0;
                  cnt_ff   <= '0;
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               // item now registered: dispatch on its code
               case (status.operation)
                  OP_LOAD:    state_ff <= ST_IDLE;
                  OP_ACC:     state_ff <= ST_ACC_RD;
                  OP_COMPUTE: state_ff <= ST_CMP_RD;
                  OP_CORRECT: state_ff <= ST_COR_RA;
                  default:    state_ff <= ST_IDLE;
               endcase
            end
            ST_ACC_RD: state_ff <= ST_ACC_WR;
            ST_ACC_WR: begin
               if (!side_ff && status.two_cells) begin
                  side_ff  <= 1'b1;
                  state_ff <= ST_ACC_RD;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_CMP_RD: state_ff <= ST_CMP_M0;
            ST_CMP_M0: state_ff <= ST_CMP_M1;
            ST_CMP_M1: state_ff <= ST_CMP_M2;
            ST_CMP_M2: state_ff <= ST_CMP_M3;
            ST_CMP_M3: state_ff <= ST_CMP_NS;
            ST_CMP_NS: begin
               step_ff  <= '0;
               state_ff <= ST_CMP_ND;
            end
            ST_CMP_ND: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == LAST_STEP) state_ff <= ST_CMP_PS;
            end
            ST_CMP_PS: begin
               step_ff  <= '0;
               state_ff <= ST_CMP_PD;
            end
            ST_CMP_PD: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == LAST_STEP) state_ff <= ST_CMP_WR;
            end
            ST_CMP_WR: begin
               cnt_ff <= cnt_ff + 1'b1;
               state_ff <= (cnt_ff == LAST_CELL) ? ST_IDLE : ST_CMP_RD;
            end
            ST_COR_RA: state_ff <= ST_COR_RB;
            ST_COR_RB: state_ff <= ST_COR_M;
            ST_COR_M:  state_ff <= ST_COR_P;
            ST_COR_P:  state_ff <= ST_COR_OUT;
            ST_COR_OUT: begin
               if (!status.rsp_full || rsp_ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.mul_sel   = MUL_ALPHA;
      cmd.cnt       = cnt_ff;
      cmd.load_item = accept;
      cmd.sel_b     = side_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.sel_cnt   = 1'b1;
            cmd.wr_sums   = 1'b1;
            cmd.sum_clear = 1'b1;
            cmd.wr_lim    = 1'b1;
            cmd.lim_clear = 1'b1;
         end
         ST_LOAD:   cmd.wr_params = (status.operation == OP_LOAD);
         ST_ACC_WR: cmd.wr_sums = 1'b1;
         ST_CMP_RD: cmd.sel_cnt = 1'b1;
         ST_CMP_M0: begin
            cmd.sel_cnt = 1'b1;
            cmd.mul_sel = MUL_VU;
         end
         ST_CMP_M1: begin
            cmd.sel_cnt = 1'b1;
            cmd.mul_sel = MUL_VBL;
            cmd.base_en = 1'b1;
         end
         ST_CMP_M2: begin
            cmd.sel_cnt = 1'b1;
            cmd.mul_sel = MUL_VBH;
            cmd.nlo_en  = 1'b1;
         end
         ST_CMP_M3: begin
            cmd.sel_cnt = 1'b1;
            cmd.nhi_en  = 1'b1;
         end
         ST_CMP_NS: begin
            cmd.sel_cnt   = 1'b1;
            cmd.div_setup = 1'b1;
            cmd.div_neg   = 1'b1;
         end
         ST_CMP_ND, ST_CMP_PD: begin
            cmd.sel_cnt  = 1'b1;
            cmd.div_step = 1'b1;
         end
         ST_CMP_PS: begin
            cmd.sel_cnt   = 1'b1;
            cmd.rn_en     = 1'b1;
            cmd.div_setup = 1'b1;
         end
         ST_CMP_WR: begin
            cmd.sel_cnt   = 1'b1;
            cmd.wr_sums   = 1'b1;
            cmd.sum_clear = 1'b1;
            cmd.wr_lim    = 1'b1;
         end
         ST_COR_RA: cmd.sel_b = 1'b0;
         ST_COR_RB: begin
            cmd.sel_b   = 1'b1;
            cmd.lima_en = 1'b1;
         end
         ST_COR_M: begin
            cmd.sel_b    = 1'b1;
            cmd.alpha_en = 1'b1;
         end
         ST_COR_OUT: cmd.rsp_load = !status.rsp_full || rsp_ready;
         default: ;
      endcase
   end

endmodule
`default_nettype wire

// ===== hdl/flux_corrected_transport_limiter_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// flux_corrected_transport_limiter_top
// zalesak flux limiter for an unstructured mesh in signed q16.16
// ----------------------------------------------------------------------------
// words are taken one at a time. after reset a clearing pass over all 1024
// cells zeroes the flux sums and sets every cell limiter to one; req_ready
// stays low meanwhile. an accumulate word does one read-modify-write of the
// sum memory per cell, for one cell on a boundary face and two on an interior
// face. a correct word makes two single-port limiter reads and one pass
// through the shared multiplier up to the result register; it then waits
// there only if the previous result has not been taken. a compute word walks
// all 1024 cells, with three passes through the multiplier and two 16-step
// restoring divisions per cell.
module flux_corrected_transport_limiter_top import fctl_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   fctl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // memories and arithmetic
   fctl_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== hdl/fctl_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fctl_checker
// port-level checks for the flux limiter
// ----------------------------------------------------------------------------
module fctl_checker import fctl_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // clearing pass blocks input after reset
   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("ready during clearing pass");

   // one word at a time
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken back to back");

   // alpha never exceeds one
   a_alpha_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.limiter_alpha <= ONE_Q16)
      else $error("alpha above one");

endmodule

bind flux_corrected_transport_limiter_top fctl_checker u_fctl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// ===== tb/sv/tb_flux_corrected_transport_limiter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flux_corrected_transport_limiter_top
// self-checking bench for the zalesak flux limiter
// ----------------------------------------------------------------------------
// a queue of request words feeds a clocked driver, and a clocked monitor takes
// the results. a behavioral copy of the limiter state predicts every correct
// word at acceptance. stimulus is a directed opening and then random phases of
// load, accumulate, compute and correct words, with random gaps on both sides
// and one long result hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_flux_corrected_transport_limiter_top;
   import fctl_pkg::*;

   localparam int unsigned RUN_LIMIT  = 2000000;
   localparam int unsigned DRAIN_WAIT = 64;
   localparam int unsigned HOLD_LEN   = 600;
   localparam longint      SUM_TOP    = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint      SUM_BOT    = -SUM_TOP - 1;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   flux_corrected_transport_limiter_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // predicted limiter state
   // ------------------------------------------------------------------------
   logic [31:0]  vol_old_mem [CELLS];
   logic [31:0]  vol_new_mem [CELLS];
   logic [31:0]  value_mem   [CELLS];
   logic [31:0]  blo_mem     [CELLS];
   logic [31:0]  bhi_mem     [CELLS];
   longint       pos_mem     [CELLS];
   longint       neg_mem     [CELLS];
   longint       dlo_mem     [CELLS];
   logic [16:0]  rp_mem      [CELLS];
   logic [16:0]  rn_mem      [CELLS];
   int unsigned  loaded_cells;

   req_type      pending_words[$];
   rsp_type      expected_flux[$];
   int unsigned  words_total;
   int unsigned  words_taken   = 0;
   int unsigned  results_taken = 0;
   int unsigned  error_count   = 0;
   int unsigned  cycle_count   = 0;
   int unsigned  gen_cells     = 0;   // contiguous loaded cells on the stimulus side
   bit           no_gaps       = 1'b0;

   initial begin
      for (int c = 0; c < CELLS; c++) begin
         pos_mem[c] = 0;
         neg_mem[c] = 0;
         dlo_mem[c] = 0;
         rp_mem[c]  = ONE_Q16;
         rn_mem[c]  = ONE_Q16;
      end
      loaded_cells = 0;
   end

   function automatic longint clamp48(input longint x);
      if (x > SUM_TOP) return SUM_TOP;
      if (x < SUM_BOT) return SUM_BOT;
      return x;
   endfunction

   function automatic logic [16:0] quotient_q16(input longint unsigned num,
                                                 input longint unsigned den);
      longint unsigned q;
      if (den == 0 || num >= den) return ONE_Q16;
      q = (num << 16) / den;
      return q[16:0];
   endfunction

   task automatic add_face_flux(input int unsigned c, input longint d, input longint lo_neg);
      pos_mem[c] = clamp48(pos_mem[c] + (d > 0 ? d : 0));
      neg_mem[c] = clamp48(neg_mem[c] + (d < 0 ? d : 0));
      dlo_mem[c] = clamp48(dlo_mem[c] + lo_neg);
   endtask

   task automatic update_limiters();
      longint v0, v1, u, bl, bh, base, nlo, nhi;
      for (int c = 0; c < CELLS; c++) begin
         rp_mem[c] = ONE_Q16;
         rn_mem[c] = ONE_Q16;
         if (c < loaded_cells) begin
            v0   = longint'({32'b0, vol_old_mem[c]});
            v1   = longint'({32'b0, vol_new_mem[c]});
            u    = longint'($signed(value_mem[c]));
            bl   = longint'($signed(blo_mem[c]));
            bh   = longint'($signed(bhi_mem[c]));
            base = ((v0 * u) >>> 16) + dlo_mem[c];
            nlo  = ((v1 * bl) >>> 16) - base;
            nhi  = ((v1 * bh) >>> 16) - base;
            if (neg_mem[c] != 0)
               rn_mem[c] = quotient_q16(nlo < 0 ? -nlo : 0, -neg_mem[c]);
            if (pos_mem[c] != 0)
               rp_mem[c] = quotient_q16(nhi > 0 ? nhi : 0, pos_mem[c]);
         end
         pos_mem[c] = 0;
         neg_mem[c] = 0;
         dlo_mem[c] = 0;
      end
   endtask

   task automatic predict_word(input req_type w);
      longint      lo, ho, d, f;
      logic [16:0] alpha, x, y;
      rsp_type     r;
      lo = longint'(w.flux_low_order);
      ho = longint'(w.flux_high_order);
      d  = lo - ho;
      case (w.operation)
         OP_LOAD: begin
            vol_old_mem[w.cell_a] = w.volume_old;
            vol_new_mem[w.cell_a] = w.volume_new;
            value_mem[w.cell_a]   = w.cell_value;
            blo_mem[w.cell_a]     = w.bound_low;
            bhi_mem[w.cell_a]     = w.bound_high;
            if (w.cell_a + 1 > loaded_cells) loaded_cells = w.cell_a + 1;
         end
         OP_ACC: begin
            add_face_flux(w.cell_a, d, -lo);
            if (w.two_cells) add_face_flux(w.cell_b, -d, lo);
         end
         OP_COMPUTE: update_limiters();
         default: begin
            alpha = ONE_Q16;
            if (w.two_cells) begin
               if (d > 0) begin
                  x = rp_mem[w.cell_a];
                  y = rn_mem[w.cell_b];
               end else begin
                  x = rn_mem[w.cell_a];
                  y = rp_mem[w.cell_b];
               end
               if (x < alpha) alpha = x;
               if (y < alpha) alpha = y;
            end
            f = lo + (((ho - lo) * longint'({47'b0, alpha})) >>> 16);
            if (f > 64'sd2147483647) f = 64'sd2147483647;
            if (f < -64'sd2147483648) f = -64'sd2147483648;
            r.corrected_flux = f[31:0];
            r.limiter_alpha  = alpha;
            expected_flux.push_back(r);
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   // mostly moderate values so limiters land between 0 and 1, plus extremes
   function automatic logic [31:0] pick_q16();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2, 3:    return $urandom();
         4, 5, 6: return {{12{1'b0}}, 20'($urandom())} - 32'h0008_0000;
         default: return {{16{1'b0}}, 16'($urandom())} - 32'h0000_8000;
      endcase
   endfunction

   function automatic logic [9:0] pick_cell();
      if ($urandom_range(0, 7) == 0 || gen_cells == 0) return 10'($urandom());
      return 10'($urandom_range(0, gen_cells + 2 > CELLS - 1 ? CELLS - 1 : gen_cells + 2));
   endfunction

   function automatic req_type random_word(input op_type op);
      req_type w;
      w.operation       = op;
      w.cell_a          = pick_cell();
      w.cell_b          = pick_cell();
      w.two_cells       = ($urandom_range(0, 4) != 0);
      w.flux_low_order  = pick_q16();
      w.flux_high_order = pick_q16();
      w.volume_old      = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 20'hFFFFF));
      w.volume_new      = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 20'hFFFFF));
      w.cell_value      = pick_q16();
      w.bound_low       = pick_q16();
      w.bound_high      = pick_q16();
      return w;
   endfunction

   // loads stay contiguous so compute never uses a cell that was never loaded
   task automatic queue_load(input req_type w);
      if (w.cell_a > gen_cells) w.cell_a = 10'(gen_cells);
      if (w.cell_a == gen_cells) gen_cells++;
      w.operation = OP_LOAD;
      pending_words.push_back(w);
   endtask

   // ------------------------------------------------------------------------
   // driver: one word at a time from the pending queue, random gap per word
   // ------------------------------------------------------------------------
   int unsigned send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_word(req_data);
            words_taken <= words_taken + 1;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               req_data  <= pending_words.pop_front();
               req_valid <= 1'b1;
               send_gap  <= no_gaps ? 0 : $urandom_range(0, 7);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor: random stall per result and one long hold-off
   // ------------------------------------------------------------------------
   int unsigned rsp_stall  = 0;
   int unsigned hold_left  = 0;
   bit          hold_done  = 1'b0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on result %0d: %s got %h expected %h", results_taken, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_taken <= results_taken + 1;
            if (expected_flux.size() == 0) begin
               report_mismatch("unexpected word", rsp_data.corrected_flux, 32'b0);
            end else begin
               want = expected_flux.pop_front();
               if (rsp_data.corrected_flux !== want.corrected_flux)
                  report_mismatch("corrected_flux", rsp_data.corrected_flux,
                                  want.corrected_flux);
               if (rsp_data.limiter_alpha !== want.limiter_alpha)
                  report_mismatch("limiter_alpha", 32'(rsp_data.limiter_alpha),
                                  32'(want.limiter_alpha));
            end
            rsp_stall <= no_gaps ? 0 : $urandom_range(0, 7);
         end
         // the long hold-off lets the result register and the input back up
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (!hold_done && results_taken >= 40) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            rsp_ready <= 1'b0;
         end else if (rsp_stall > 0 && !(rsp_valid && rsp_ready)) begin
            rsp_stall <= rsp_stall - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(rsp_valid && rsp_ready && !no_gaps);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("** flux_corrected_transport_limiter_top: FAILED **");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      req_type w;
      // directed opening: extremes of loads, boundary and same-cell faces
      w = random_word(OP_LOAD);
      w.cell_a = 0; w.volume_old = 32'h0; w.volume_new = 32'hFFFF_FFFF;
      w.cell_value = 32'h8000_0000; w.bound_low = 32'h8000_0000; w.bound_high = 32'h7FFF_FFFF;
      queue_load(w);
      w = random_word(OP_LOAD);
      w.cell_a = 1; w.volume_old = 32'hFFFF_FFFF; w.volume_new = 32'h0;
      w.cell_value = 32'h7FFF_FFFF; w.bound_low = 32'h7FFF_FFFF; w.bound_high = 32'h8000_0000;
      queue_load(w);
      w = random_word(OP_LOAD);
      w.cell_a = 2; w.volume_old = 32'h0001_0000; w.volume_new = 32'h0001_0000;
      w.cell_value = 32'h0; w.bound_low = 32'hFFFF_0000; w.bound_high = 32'h0001_0000;
      queue_load(w);
      // interior, boundary, same-cell and unloaded-cell faces
      w = random_word(OP_ACC); w.cell_a = 0; w.cell_b = 1; w.two_cells = 1;
      w.flux_low_order = 32'h7FFF_FFFF; w.flux_high_order = 32'h8000_0000;
      pending_words.push_back(w);
      w = random_word(OP_ACC); w.cell_a = 2; w.two_cells = 0;
      w.flux_low_order = 32'h0000_4000; w.flux_high_order = 32'h0002_0000;
      pending_words.push_back(w);
      w = random_word(OP_ACC); w.cell_a = 2; w.cell_b = 2; w.two_cells = 1;
      pending_words.push_back(w);
      w = random_word(OP_ACC); w.cell_a = 10'h3FF; w.cell_b = 10'h200; w.two_cells = 1;
      pending_words.push_back(w);
      // correct before any compute: limiters are still one
      w = random_word(OP_CORRECT); w.cell_a = 0; w.cell_b = 1; w.two_cells = 1;
      w.flux_low_order = 32'h8000_0000; w.flux_high_order = 32'h7FFF_FFFF;
      pending_words.push_back(w);
      pending_words.push_back(random_word(OP_COMPUTE));
      for (int i = 0; i < 4; i++) begin
         w = random_word(OP_CORRECT);
         w.cell_a = 10'(i % 3); w.cell_b = 10'((i + 1) % 3); w.two_cells = (i != 3);
         pending_words.push_back(w);
      end
      w = random_word(OP_CORRECT); w.cell_a = 10'h3FF; w.cell_b = 10'h3FE; w.two_cells = 1;
      pending_words.push_back(w);
      // second compute with cleared sums gives all-one limiters again
      pending_words.push_back(random_word(OP_COMPUTE));
      w = random_word(OP_CORRECT); w.cell_a = 0; w.cell_b = 2; w.two_cells = 1;
      pending_words.push_back(w);

      // random phases: loads, faces, one compute, corrections, a little noise
      for (int p = 0; p < 5; p++) begin
         for (int i = 0; i < 25; i++) queue_load(random_word(OP_LOAD));
         for (int i = 0; i < 120; i++) begin
            if ($urandom_range(0, 19) == 0) pending_words.push_back(random_word(OP_CORRECT));
            else pending_words.push_back(random_word(OP_ACC));
         end
         pending_words.push_back(random_word(OP_COMPUTE));
         for (int i = 0; i < 120; i++) begin
            if ($urandom_range(0, 19) == 0) queue_load(random_word(OP_LOAD));
            else pending_words.push_back(random_word(OP_CORRECT));
         end
      end
      words_total = pending_words.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // gap-free stretch in the middle of the run
      wait (words_taken >= words_total / 2);
      no_gaps = 1'b1;
      wait (words_taken >= words_total / 2 + 80);
      no_gaps = 1'b0;

      wait (words_taken == words_total && expected_flux.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("** flux_corrected_transport_limiter_top: PASSED **");
      else
         $display("** flux_corrected_transport_limiter_top: FAILED **");
      $finish;
   end

endmodule

// ===== flux_corrected_transport_limiter_top.f =====
hdl/fctl_pkg.sv
hdl/fctl_datapath.sv
hdl/fctl_ctrl.sv
hdl/flux_corrected_transport_limiter_top.sv
hdl/fctl_checker.sv
tb/sv/tb_flux_corrected_transport_limiter_top.sv
